// ===== design/wfps_pkg.sv =====
// shared types, constants and helpers for the wall-follow steering block
`timescale 1ns / 1ps
package wfps_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int PWM_MAX        = 255;

  localparam int DIST_W  = 8;
  localparam int GAIN_W  = 12;
  localparam int SPEED_W = 8;
  localparam int DT_W    = 16;
  localparam int PWM_W   = 8;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 3;

  localparam int ERR_W      = 9;   // error is -255..255
  localparam int DIFF_W     = 10;  // err - prev is -510..510
  localparam int ERR_MAG_W  = 8;
  localparam int DIFF_MAG_W = 9;
  localparam int PROD_P_W   = GAIN_W + ERR_MAG_W;   // kp * |err|
  localparam int PROD_D_W   = GAIN_W + DIFF_MAG_W;  // kd * |diff|
  localparam int NUM_W      = PROD_D_W + 10;        // kd * |diff| * 1000
  localparam int TURN_W     = NUM_W + 2;
  localparam int DUTY_W     = TURN_W + 1;

  localparam int MUL_STEPS = DIFF_MAG_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [DIST_W-1:0] left_dist;
    logic              left_ok;
    logic [DIST_W-1:0] front_dist;
    logic              front_ok;
    logic [DIST_W-1:0] right_dist;
    logic              right_ok;
    logic [DT_W-1:0]   elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [PWM_W-1:0] left_pwm;
    logic [PWM_W-1:0] right_pwm;
    logic             front_blocked;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } wfps_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN     = 3'd0,
    CFG_DERIV_GAIN    = 3'd1,
    CFG_CRUISE_SPEED  = 3'd2,
    CFG_SLOW_SPEED    = 3'd3,
    CFG_TARGET_SIDE   = 3'd4,
    CFG_FRONT_SLOW    = 3'd5,
    CFG_FRONT_STOP    = 3'd6,
    CFG_NO_WALL       = 3'd7
  } cfg_idx_t;

  // drop the fraction bits, clamp to 0..PWM_MAX
  function automatic logic [PWM_W-1:0] duty_of(input logic signed [DUTY_W-1:0] q);
    logic signed [DUTY_W-GAIN_FRAC_BITS-1:0] v;
    logic [PWM_W-1:0] r;
    v = (DUTY_W-GAIN_FRAC_BITS)'(q >>> GAIN_FRAC_BITS);
    if (q < 0) begin
      r = '0;
    end else if (v > (DUTY_W-GAIN_FRAC_BITS)'(PWM_MAX)) begin
      r = PWM_W'(PWM_MAX);
    end else begin
      r = v[PWM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/wfps_mult.sv =====
// bit-serial shift-add multipliers for the proportional and derivative products
`timescale 1ns / 1ps
module wfps_mult import wfps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [GAIN_W-1:0]     prop_gain,
  input  logic [GAIN_W-1:0]     deriv_gain,
  input  logic [ERR_MAG_W-1:0]  err_mag,
  input  logic [DIFF_MAG_W-1:0] diff_mag,
  output logic                  done,
  output logic [PROD_P_W-1:0]   prod_p,
  output logic [PROD_D_W-1:0]   prod_d
);

  logic                  busy;
  logic [MUL_CNT_W-1:0]  cnt;
  logic [PROD_P_W-1:0]   mc_p;
  logic [PROD_D_W-1:0]   mc_d;
  logic [DIFF_MAG_W-1:0] mr_p;
  logic [DIFF_MAG_W-1:0] mr_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= MUL_CNT_W'(MUL_STEPS - 1);
        mc_p   <= PROD_P_W'(prop_gain);
        mc_d   <= PROD_D_W'(deriv_gain);
        mr_p   <= DIFF_MAG_W'(err_mag);
        mr_d   <= diff_mag;
        prod_p <= '0;
        prod_d <= '0;
      end else if (busy) begin
        // one multiplier bit per cycle, lsb first
        if (mr_p[0]) prod_p <= prod_p + mc_p;
        if (mr_d[0]) prod_d <= prod_d + mc_d;
        mc_p <= mc_p << 1;
        mc_d <= mc_d << 1;
        mr_p <= mr_p >> 1;
        mr_d <= mr_d >> 1;
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/wfps_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module wfps_div import wfps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DT_W-1:0]  den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DT_W-1:0]      rem;
  logic [DT_W-1:0]      dvs;
  logic [DT_W:0]        trial;
  logic                 fits;

  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
        rem  <= '0;
        dvs  <= den;
        quot <= num;
      end else if (busy) begin
        // dividend bits shift out the top as quotient bits shift in
        rem  <= fits ? DT_W'(trial - {1'b0, dvs}) : trial[DT_W-1:0];
        quot <= {quot[NUM_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/wall_follow_pd_steering.sv =====
// top level: wall-follow pd steering with serial multiply and divide
//
// usage
//   in_valid/in_ready carry one in_data transaction per sensor update:
//   three distances with ok flags and the elapsed milliseconds.
//   out_valid/out_ready carry one out_data transaction per input: left and
//   right pwm duties and the front-blocked flag.
//   cfg_we/cfg_index/cfg_data write one gain or threshold register per
//   cycle; write only while no transaction is in flight.
//   a driving update runs a shift-add multiply and then a restoring divide
//   by the elapsed time; the result is registered in the output register,
//   in_ready is high again in that same cycle, so a new update is taken
//   only once the last is through. the divider loop is the longest step.
//   a front-stop update skips the arithmetic and goes straight to ST_OUT.
//   if out_ready is low the finished result waits in the output register;
//   one more input is still accepted and computed, then held until the
//   register frees, and in_ready stays low meanwhile.
//   reset (rst, synchronous) restores the register defaults, clears the
//   stored previous error and empties the output register.
`timescale 1ns / 1ps
module wall_follow_pd_steering import wfps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration registers
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  deriv_gain;
  logic [SPEED_W-1:0] cruise_speed;
  logic [SPEED_W-1:0] slow_speed;
  logic [DIST_W-1:0]  side_target;
  logic [DIST_W-1:0]  slow_dist;
  logic [DIST_W-1:0]  stop_dist;
  logic [DIST_W-1:0]  wall_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= GAIN_W'(205);
      deriv_gain   <= GAIN_W'(26);
      cruise_speed <= SPEED_W'(150);
      slow_speed   <= SPEED_W'(70);
      side_target  <= DIST_W'(50);
      slow_dist    <= DIST_W'(80);
      stop_dist    <= DIST_W'(35);
      wall_limit   <= DIST_W'(100);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PROP_GAIN:    prop_gain    <= cfg_data;
        CFG_DERIV_GAIN:   deriv_gain   <= cfg_data;
        CFG_CRUISE_SPEED: cruise_speed <= cfg_data[SPEED_W-1:0];
        CFG_SLOW_SPEED:   slow_speed   <= cfg_data[SPEED_W-1:0];
        CFG_TARGET_SIDE:  side_target  <= cfg_data[DIST_W-1:0];
        CFG_FRONT_SLOW:   slow_dist    <= cfg_data[DIST_W-1:0];
        CFG_FRONT_STOP:   stop_dist    <= cfg_data[DIST_W-1:0];
        CFG_NO_WALL:      wall_limit   <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // wall detection and error selection on the incoming item
  logic                     lw, fw, rw;
  logic                     stop_now;
  logic signed [ERR_W-1:0]  err_now;
  logic signed [DIFF_W-1:0] diff_now;
  logic [ERR_MAG_W-1:0]     err_mag;
  logic [DIFF_MAG_W-1:0]    diff_mag;
  logic signed [ERR_W-1:0]  prev_error;

  assign lw = in_data.left_ok  && (in_data.left_dist  <= wall_limit);
  assign fw = in_data.front_ok && (in_data.front_dist <= wall_limit);
  assign rw = in_data.right_ok && (in_data.right_dist <= wall_limit);
  assign stop_now = fw && (in_data.front_dist < stop_dist);

  always_comb begin
    if (lw && rw) begin
      err_now = $signed({1'b0, in_data.left_dist}) - $signed({1'b0, in_data.right_dist});
    end else if (lw) begin
      err_now = $signed({1'b0, in_data.left_dist}) - $signed({1'b0, side_target});
    end else if (rw) begin
      err_now = $signed({1'b0, side_target}) - $signed({1'b0, in_data.right_dist});
    end else begin
      err_now = '0;
    end
    diff_now = DIFF_W'(err_now) - DIFF_W'(prev_error);
    err_mag  = err_now[ERR_W-1]   ? ERR_MAG_W'(-err_now)   : err_now[ERR_MAG_W-1:0];
    diff_mag = diff_now[DIFF_W-1] ? DIFF_MAG_W'(-diff_now) : diff_now[DIFF_MAG_W-1:0];
  end

  // sequencer
  wfps_state_t state, state_next;
  logic        accept;
  logic        mul_start, mul_done;
  logic        div_start, div_done;
  logic        load_turn, load_out;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    load_turn  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mul_start  = !stop_now;
          state_next = stop_now ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          load_turn  = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // per-item registers
  logic                     stop_r;
  logic                     err_neg;
  logic                     diff_neg;
  logic [SPEED_W-1:0]       base;
  logic [DT_W-1:0]          dt;
  logic signed [TURN_W-1:0] turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
    end else if (accept && !stop_now) begin
      prev_error <= err_now;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stop_r   <= stop_now;
      err_neg  <= err_now[ERR_W-1];
      diff_neg <= diff_now[DIFF_W-1];
      base     <= (fw && (in_data.front_dist < slow_dist)) ? slow_speed : cruise_speed;
      dt       <= (in_data.elapsed_ms == '0) ? DT_W'(1) : in_data.elapsed_ms;
    end
  end

  // products, then derivative numerator divided by elapsed time
  logic [PROD_P_W-1:0] prod_p;
  logic [PROD_D_W-1:0] prod_d;
  logic [NUM_W-1:0]    num;
  logic [NUM_W-1:0]    quot;

  wfps_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .start      (mul_start),
    .prop_gain  (prop_gain),
    .deriv_gain (deriv_gain),
    .err_mag    (err_mag),
    .diff_mag   (diff_mag),
    .done       (mul_done),
    .prod_p     (prod_p),
    .prod_d     (prod_d)
  );

  // x * 1000 = x * 1024 - x * 16 - x * 8
  assign num = (NUM_W'(prod_d) << 10) - (NUM_W'(prod_d) << 4) - (NUM_W'(prod_d) << 3);

  wfps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (dt),
    .done  (div_done),
    .quot  (quot)
  );

  logic signed [TURN_W-1:0] p_term, d_term;

  always_comb begin
    p_term = $signed(TURN_W'(prod_p));
    d_term = $signed(TURN_W'(quot));
    if (err_neg)  p_term = -p_term;
    if (diff_neg) d_term = -d_term;
  end

  always_ff @(posedge clk) begin
    if (load_turn) begin
      turn <= p_term + d_term;
    end
  end

  // output register
  logic signed [DUTY_W-1:0] base_q, turn_x, left_q, right_q;

  assign base_q  = $signed(DUTY_W'({base, {GAIN_FRAC_BITS{1'b0}}}));
  assign turn_x  = DUTY_W'(turn);
  assign left_q  = base_q + turn_x;
  assign right_q = base_q - turn_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (stop_r) begin
        out_data.left_pwm      <= '0;
        out_data.right_pwm     <= '0;
        out_data.front_blocked <= 1'b1;
      end else begin
        out_data.left_pwm      <= duty_of(left_q);
        out_data.right_pwm     <= duty_of(right_q);
        out_data.front_blocked <= 1'b0;
      end
    end
  end

  // checks
  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL)
    else $error("multiplier finished outside the multiply phase");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_stop_keeps_prev: assert property (@(posedge clk) disable iff (rst)
    (accept && stop_now) |=> ($stable(prev_error) && state == ST_OUT))
    else $error("front-stop transaction disturbed the previous error");

  a_blocked_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.front_blocked) |->
      (out_data.left_pwm == '0 && out_data.right_pwm == '0))
    else $error("blocked result with non-zero duty");

endmodule

// ===== test/wall_follow_pd_steering_tb.sv =====
// testbench for the wall-follow pd steering block: directed and random sensor updates
`timescale 1ns / 1ps
module wall_follow_pd_steering_tb;
  import wfps_pkg::*;

  localparam int UPD_W = $bits(in_item_t);

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  wall_follow_pd_steering dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // shadow copy of the gain and threshold registers
  int m_kp = 205;
  int m_kd = 26;
  int m_cruise = 150;
  int m_slow = 70;
  int m_target = 50;
  int m_front_slow = 80;
  int m_front_stop = 35;
  int m_no_wall = 100;
  longint last_err = 0;

  in_item_t  sensor_queue[$];
  out_item_t duty_expected[$];
  out_item_t want;

  int  accepted = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  stops = 0;
  int  rail_hits = 0;
  int  settings = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  rx_park = 0;
  bit  calm = 1'b0;

  localparam int PARK_AT = 250;
  localparam int PARK_CYCLES = 600;

  function automatic logic [PWM_W-1:0] duty_clamp(input longint q);
    longint v;
    if (q < 0) return '0;
    v = q >>> GAIN_FRAC_BITS;
    if (v > PWM_MAX) v = PWM_MAX;
    return PWM_W'(v);
  endfunction

  function automatic out_item_t steer_predict(input in_item_t u);
    int l, f, rr;
    bit lw, fw, rw;
    longint err, base_q, turn, dterm, dt;
    out_item_t r;
    l = u.left_dist;
    f = u.front_dist;
    rr = u.right_dist;
    lw = u.left_ok && l <= m_no_wall;
    fw = u.front_ok && f <= m_no_wall;
    rw = u.right_ok && rr <= m_no_wall;
    // front stop: motors off, previous error left alone
    if (fw && f < m_front_stop) begin
      r.left_pwm = '0;
      r.right_pwm = '0;
      r.front_blocked = 1'b1;
      stops++;
      return r;
    end
    if (lw && rw) err = l - rr;
    else if (lw) err = l - m_target;
    else if (rw) err = m_target - rr;
    else err = 0;
    base_q = (fw && f < m_front_slow) ? m_slow : m_cruise;
    dt = u.elapsed_ms;
    if (dt == 0) dt = 1;
    dterm = (longint'(m_kd) * (err - last_err) * 1000) / dt;
    turn = longint'(m_kp) * err + dterm;
    last_err = err;
    base_q = base_q <<< GAIN_FRAC_BITS;
    r.left_pwm = duty_clamp(base_q + turn);
    r.right_pwm = duty_clamp(base_q - turn);
    r.front_blocked = 1'b0;
    if (r.left_pwm == '0 || r.left_pwm == PWM_W'(PWM_MAX) ||
        r.right_pwm == '0 || r.right_pwm == PWM_W'(PWM_MAX)) rail_hits++;
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] near(input int centre);
    int v;
    v = centre + $urandom_range(0, 10) - 5;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return DIST_W'(v);
  endfunction

  function automatic logic [DIST_W-1:0] side_dist();
    case ($urandom_range(0, 3))
      0: return DIST_W'($urandom_range(0, 255));
      1: return near(m_no_wall);
      2: return near(m_target);
      default: return DIST_W'($urandom_range(0, m_no_wall));
    endcase
  endfunction

  function automatic in_item_t random_update();
    in_item_t u;
    int pick;
    // occasional raw noise across every bit
    if ($urandom_range(0, 9) == 0) begin
      u = UPD_W'({$urandom, $urandom});
      return u;
    end
    u.left_ok = ($urandom_range(0, 7) != 0);
    u.right_ok = ($urandom_range(0, 7) != 0);
    u.front_ok = ($urandom_range(0, 7) != 0);
    u.left_dist = side_dist();
    u.right_dist = side_dist();
    case ($urandom_range(0, 3))
      0: u.front_dist = DIST_W'($urandom_range(0, 255));
      1: u.front_dist = near(m_front_stop);
      2: u.front_dist = near(m_front_slow);
      default: u.front_dist = near(m_no_wall);
    endcase
    pick = $urandom_range(0, 7);
    if (pick == 0) u.elapsed_ms = '0;
    else if (pick == 1) u.elapsed_ms = DT_W'($urandom);
    else u.elapsed_ms = DT_W'($urandom_range(1, 30));
    return u;
  endfunction

  // sender: offers queued updates, predicts each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        duty_expected.push_back(steer_predict(in_data));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (sensor_queue.size() != 0) begin
          in_data <= sensor_queue.pop_front();
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (duty_expected.size() == 0) begin
          $error("unexpected result: left_pwm %0d right_pwm %0d front_blocked %0d",
                 out_data.left_pwm, out_data.right_pwm, out_data.front_blocked);
          mismatches++;
        end else begin
          want = duty_expected.pop_front();
          if (out_data.left_pwm !== want.left_pwm) begin
            $error("left_pwm: expected %0d, got %0d", want.left_pwm, out_data.left_pwm);
            mismatches++;
          end
          if (out_data.right_pwm !== want.right_pwm) begin
            $error("right_pwm: expected %0d, got %0d", want.right_pwm, out_data.right_pwm);
            mismatches++;
          end
          if (out_data.front_blocked !== want.front_blocked) begin
            $error("front_blocked: expected %0d, got %0d", want.front_blocked,
                   out_data.front_blocked);
            mismatches++;
          end
        end
        // one long hold-off so the block backs up into its input
        if (results_seen == PARK_AT) rx_park = PARK_CYCLES;
      end
      if (rx_park > 0) begin
        rx_park--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PROP_GAIN:    m_kp = val;
      CFG_DERIV_GAIN:   m_kd = val;
      CFG_CRUISE_SPEED: m_cruise = val[7:0];
      CFG_SLOW_SPEED:   m_slow = val[7:0];
      CFG_TARGET_SIDE:  m_target = val[7:0];
      CFG_FRONT_SLOW:   m_front_slow = val[7:0];
      CFG_FRONT_STOP:   m_front_stop = val[7:0];
      CFG_NO_WALL:      m_no_wall = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] kd,
                              input logic [CFG_W-1:0] cruise, input logic [CFG_W-1:0] slow,
                              input logic [CFG_W-1:0] target, input logic [CFG_W-1:0] fslow,
                              input logic [CFG_W-1:0] fstop, input logic [CFG_W-1:0] nowall);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_DERIV_GAIN, kd);
    write_reg(CFG_CRUISE_SPEED, cruise);
    write_reg(CFG_SLOW_SPEED, slow);
    write_reg(CFG_TARGET_SIDE, target);
    write_reg(CFG_FRONT_SLOW, fslow);
    write_reg(CFG_FRONT_STOP, fstop);
    write_reg(CFG_NO_WALL, nowall);
    settings++;
  endtask

  // 8-bit registers get junk in the upper bits, which must be dropped
  function automatic logic [CFG_W-1:0] wide8(input int v);
    return {4'($urandom), 8'(v)};
  endfunction

  function automatic logic [CFG_W-1:0] rand_gain();
    if ($urandom_range(0, 3) == 0) return CFG_W'($urandom);
    return CFG_W'($urandom_range(0, 600));
  endfunction

  task automatic push_update(input int l, input bit lo, input int f, input bit fo,
                             input int r, input bit ro, input int dt);
    in_item_t u;
    u.left_dist = DIST_W'(l);
    u.left_ok = lo;
    u.front_dist = DIST_W'(f);
    u.front_ok = fo;
    u.right_dist = DIST_W'(r);
    u.right_ok = ro;
    u.elapsed_ms = DT_W'(dt);
    sensor_queue.push_back(u);
  endtask

  // stimulus waits until every queued update is sent and every prediction has been matched
  task automatic wait_drained();
    while (sensor_queue.size() != 0 || in_valid || duty_expected.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 150;

  initial begin
    int ph, n, fs;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: wall cases, front thresholds, elapsed-time extremes
    push_update(60, 1, 200, 1, 40, 1, 10);
    push_update(40, 1, 255, 1, 60, 1, 10);
    push_update(70, 1, 255, 0, 255, 1, 0);
    push_update(255, 1, 0, 0, 30, 1, 1);
    push_update(255, 1, 255, 1, 255, 1, 65535);
    push_update(0, 0, 0, 0, 0, 0, 5);
    push_update(100, 1, 60, 1, 0, 1, 20);
    push_update(0, 1, 79, 1, 100, 1, 20);
    push_update(50, 1, 80, 1, 50, 1, 20);
    push_update(50, 1, 34, 1, 50, 1, 20);
    push_update(50, 1, 35, 1, 50, 1, 20);
    push_update(50, 1, 0, 1, 50, 1, 20);
    push_update(50, 1, 10, 0, 50, 1, 20);
    push_update(0, 1, 101, 1, 0, 1, 3);
    push_update(101, 1, 255, 1, 99, 1, 7);
    push_update(100, 1, 100, 1, 100, 1, 1);
    push_update(0, 1, 255, 1, 100, 1, 65535);
    push_update(100, 1, 255, 1, 0, 1, 0);
    push_update(0, 1, 255, 1, 100, 1, 1);
    push_update(85, 1, 20, 1, 15, 1, 9);
    push_update(85, 1, 255, 1, 15, 1, 9);
    push_update(170, 0, 170, 0, 170, 0, 16'hAAAA);
    push_update(85, 1, 85, 1, 85, 1, 16'h5555);
    wait_drained();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        load_setting('0, '0, '0, '0, '0, '0, '0, '0);
      end else if (ph == 1) begin
        load_setting('1, '1, '1, '1, '1, '1, '1, '1);
      end else if (ph == 2) begin
        load_setting(205, 26, wide8(150), wide8(70), wide8(50), wide8(80), wide8(35),
                     wide8(100));
      end else begin
        fs = $urandom_range(0, 80);
        load_setting(rand_gain(), rand_gain(), wide8($urandom_range(0, 255)),
                     wide8($urandom_range(0, 255)), wide8($urandom_range(0, 255)),
                     wide8($urandom_range(fs, 200)), wide8(fs),
                     wide8($urandom_range(40, 255)));
      end
      if (ph == PHASES - 1) calm = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) sensor_queue.push_back(random_update());
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (duty_expected.size() != 0) begin
      $error("%0d predicted results never arrived", duty_expected.size());
      mismatches++;
    end
    $display("covered %0d sensor updates under %0d register settings, %0d of them front stops",
             accepted, settings, stops);
    $display("%0d driving results touched a duty rail; receiver held off %0d cycles once",
             rail_hits, PARK_CYCLES);
    if (mismatches == 0) begin
      $display("wall_follow_pd_steering: match");
    end else begin
      $display("wall_follow_pd_steering: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("wall_follow_pd_steering: mismatch");
    $finish;
  end

endmodule
